// ----- sv/i2cb_pkg.sv -----
package i2cb_pkg;

    localparam logic [2:0] OP_IDLE      = 3'd0;
    localparam logic [2:0] OP_START     = 3'd1;
    localparam logic [2:0] OP_STOP      = 3'd2;
    localparam logic [2:0] OP_WRITE     = 3'd3;
    localparam logic [2:0] OP_READ_ACK  = 3'd4;
    localparam logic [2:0] OP_READ_NACK = 3'd5;

    localparam logic [2:0] STEP_0 = 3'd0;
    localparam logic [2:0] STEP_1 = 3'd1;
    localparam logic [2:0] STEP_2 = 3'd2;
    localparam logic [2:0] STEP_3 = 3'd3;
    localparam logic [2:0] STEP_4 = 3'd4;

    localparam logic [3:0]  BITS_PER_BYTE     = 4'd8;
    localparam logic [15:0] PHASE_TICKS_RESET = 16'd5;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rd_data;
        logic       ack_ok;
    } t_result;

endpackage

// ----- sv/i2cb_engine.sv -----
module i2cb_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [15:0]      i_cfg_data,
    input  logic             i_step,
    input  logic [2:0]       i_cmd,
    input  logic [7:0]       i_wr_data,
    input  logic             i_sda_in,
    output i2cb_pkg::t_result o_result
);
    import i2cb_pkg::*;

    logic [15:0] r_phase_ticks;
    logic [2:0]  r_op,    n_op;
    logic [2:0]  r_pstep, n_pstep;
    logic [15:0] r_tick,  n_tick;
    logic [3:0]  r_bit,   n_bit;
    logic [7:0]  r_shift, n_shift;
    logic        r_ack,   n_ack;
    logic        r_scl,   n_scl;
    logic        r_sda,   n_sda;
    logic [7:0]  r_rx,    n_rx;
    logic        n_done;
    logic [15:0] limit;

    assign limit = (r_phase_ticks == 16'd0) ? 16'd1 : r_phase_ticks;

    always_comb begin
        n_op    = r_op;
        n_pstep = r_pstep;
        n_tick  = r_tick;
        n_bit   = r_bit;
        n_shift = r_shift;
        n_ack   = r_ack;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_rx    = r_rx;
        n_done  = 1'b0;
        if (r_op == OP_IDLE) begin
            if (i_cmd >= OP_START && i_cmd <= OP_READ_NACK) begin
                n_op    = i_cmd;
                n_bit   = 4'd0;
                n_pstep = STEP_0;
                n_tick  = 16'd1;
                n_scl   = 1'b1;
                case (i_cmd)
                    OP_START: begin
                        n_sda = 1'b1;
                    end
                    OP_STOP: begin
                        n_sda = 1'b0;
                    end
                    OP_WRITE: begin
                        n_shift = i_wr_data;
                        n_sda   = i_wr_data[7];
                    end
                    default: begin
                        n_shift = 8'd0;
                        n_sda   = 1'b1;
                    end
                endcase
            end
        end else if (r_tick >= limit) begin
            n_tick = 16'd1;
            case (r_op)
                OP_START: begin
                    if (r_pstep == STEP_0) begin
                        n_sda   = 1'b0;
                        n_pstep = STEP_1;
                    end else begin
                        n_scl  = 1'b0;
                        n_done = 1'b1;
                    end
                end
                OP_STOP: begin
                    if (r_pstep == STEP_0) begin
                        n_sda   = 1'b1;
                        n_pstep = STEP_1;
                    end else begin
                        n_done = 1'b1;
                    end
                end
                OP_WRITE: begin
                    case (r_pstep)
                        STEP_0: begin
                            n_scl   = 1'b0;
                            n_pstep = STEP_1;
                        end
                        STEP_1: begin
                            n_shift = {r_shift[6:0], 1'b0};
                            n_bit   = r_bit + 4'd1;
                            n_scl   = 1'b1;
                            if (n_bit < BITS_PER_BYTE) begin
                                n_sda   = r_shift[6];
                                n_pstep = STEP_0;
                            end else begin
                                n_sda   = 1'b1;
                                n_pstep = STEP_2;
                            end
                        end
                        STEP_2: begin
                            n_ack   = ~i_sda_in;
                            n_pstep = STEP_3;
                        end
                        STEP_3: begin
                            n_scl   = 1'b0;
                            n_pstep = STEP_4;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
                default: begin
                    case (r_pstep)
                        STEP_0: begin
                            n_shift = {r_shift[6:0], i_sda_in};
                            n_scl   = 1'b0;
                            n_bit   = r_bit + 4'd1;
                            n_pstep = STEP_1;
                        end
                        STEP_1: begin
                            n_scl = 1'b1;
                            if (r_bit < BITS_PER_BYTE) begin
                                n_pstep = STEP_0;
                            end else begin
                                n_sda   = (r_op == OP_READ_ACK) ? 1'b0 : 1'b1;
                                n_pstep = STEP_2;
                            end
                        end
                        default: begin
                            n_scl  = 1'b0;
                            n_sda  = 1'b1;
                            n_rx   = r_shift;
                            n_done = 1'b1;
                        end
                    endcase
                end
            endcase
            if (n_done) begin
                n_op    = OP_IDLE;
                n_pstep = STEP_0;
                n_tick  = 16'd0;
            end
        end else begin
            n_tick = r_tick + 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_TICKS_RESET;
            r_op          <= OP_IDLE;
            r_pstep       <= STEP_0;
            r_tick        <= 16'd0;
            r_bit         <= 4'd0;
            r_shift       <= 8'd0;
            r_ack         <= 1'b0;
            r_scl         <= 1'b1;
            r_sda         <= 1'b1;
            r_rx          <= 8'd0;
        end else begin
            if (i_cfg_we) begin
                r_phase_ticks <= i_cfg_data;
            end
            if (i_step) begin
                r_op    <= n_op;
                r_pstep <= n_pstep;
                r_tick  <= n_tick;
                r_bit   <= n_bit;
                r_shift <= n_shift;
                r_ack   <= n_ack;
                r_scl   <= n_scl;
                r_sda   <= n_sda;
                r_rx    <= n_rx;
            end
        end
    end

    assign o_result.scl_out  = n_scl;
    assign o_result.sda_out  = n_sda;
    assign o_result.busy_res = (n_op != OP_IDLE);
    assign o_result.done_res = n_done;
    assign o_result.rd_data  = n_rx;
    assign o_result.ack_ok   = n_ack;

endmodule

// ----- sv/i2cb_out_reg.sv -----
module i2cb_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  i2cb_pkg::t_result i_result,
    input  logic              i_take,
    output logic              o_valid,
    output i2cb_pkg::t_result o_result
);
    import i2cb_pkg::*;

    logic    r_valid;
    t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ----- sv/i2c_bit_level_master.sv -----
// channel   direction  handshake                  payload
// cfg       in         i_cfg_valid / o_cfg_ready  i_cfg_data (phase_ticks)
// in        in         i_in_valid / o_in_ready    i_cmd, i_wr_data, i_sda_in
// out       out        o_out_valid / i_out_ready  o_scl_out .. o_ack_ok
//
// one tick beat in, one result beat out, one beat per cycle sustained while each result is taken
// the result is computed in the cycle of acceptance and held in the output register
// a tick is taken whenever the output register is empty or being emptied
// synchronous active-low reset: idle, scl and sda released, phase_ticks 5
// configuration writes are taken every cycle
module i2c_bit_level_master (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_cmd,
    input  logic [7:0]  i_wr_data,
    input  logic        i_sda_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_scl_out,
    output logic        o_sda_out,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic [7:0]  o_rd_data,
    output logic        o_ack_ok
);
    import i2cb_pkg::*;

    t_result step_result;
    t_result out_result;
    logic    in_beat;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !o_out_valid || i_out_ready;
    assign in_beat     = i_in_valid && o_in_ready;

    i2cb_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_step     (in_beat),
        .i_cmd      (i_cmd),
        .i_wr_data  (i_wr_data),
        .i_sda_in   (i_sda_in),
        .o_result   (step_result)
    );

    i2cb_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (in_beat),
        .i_result (step_result),
        .i_take   (i_out_ready),
        .o_valid  (o_out_valid),
        .o_result (out_result)
    );

    assign o_scl_out  = out_result.scl_out;
    assign o_sda_out  = out_result.sda_out;
    assign o_busy_res = out_result.busy_res;
    assign o_done_res = out_result.done_res;
    assign o_rd_data  = out_result.rd_data;
    assign o_ack_ok   = out_result.ack_ok;

endmodule

// ----- sv/i2cb_checker.sv -----
module i2cb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_scl_out,
    input logic       o_sda_out,
    input logic       o_busy_res,
    input logic       o_done_res,
    input logic [7:0] o_rd_data,
    input logic       o_ack_ok
);

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_done_res && o_busy_res))
        else $error("done and busy in the same beat");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    a_beat_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> o_out_valid)
        else $error("accepted tick gave no result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_scl_out)
            && $stable(o_sda_out) && $stable(o_rd_data) && $stable(o_ack_ok)))
        else $error("stalled result changed");

endmodule

bind i2c_bit_level_master i2cb_checker u_i2cb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_scl_out   (o_scl_out),
    .o_sda_out   (o_sda_out),
    .o_busy_res  (o_busy_res),
    .o_done_res  (o_done_res),
    .o_rd_data   (o_rd_data),
    .o_ack_ok    (o_ack_ok)
);
